// ===== rtl/core/event_subscription_table_top_macros.svh =====
// ---------------------------------------------------------------------------
// Event subscription table: assertion macros
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef EVENT_SUBSCRIPTION_TABLE_TOP_MACROS_SVH
`define EVENT_SUBSCRIPTION_TABLE_TOP_MACROS_SVH

// same-cycle implication, ignored while in reset
`define ESUB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, ignored while in reset
`define ESUB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, checked through reset as well
`define ESUB_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/esub_pkg.sv =====
// ---------------------------------------------------------------------------
// Event subscription table: package
// Sizes, codes and transaction types shared by the block.
// ---------------------------------------------------------------------------
package esub_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int OWNER_BITS  = 8;
   localparam int EVENT_BITS  = 8;
   localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_BITS    = 5;

   typedef enum logic [1:0] {
      ACT_SUBSCRIBE   = 2'd0,
      ACT_UNSUB_SLOT  = 2'd1,
      ACT_UNSUB_MATCH = 2'd2,
      ACT_DISPATCH    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_FULL     = 2'd1,
      ST_NO_MATCH = 2'd2,
      ST_DROPPED  = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } state_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  owner_id;
      logic [7:0]  event_code;
      logic [3:0]  slot;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  slot_index;
      logic [7:0]  owner_out;
      logic [4:0]  removed_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic                  en;
      logic                  code_en;
      logic [IDX_BITS-1:0]   idx;
      logic [OWNER_BITS-1:0] owner;
      logic [EVENT_BITS-1:0] code;
   } wr_type;

endpackage

// ===== rtl/core/esub_store.sv =====
// ---------------------------------------------------------------------------
// Event subscription table: slot store
// Owner and event tables with one write port and one read port.
// ---------------------------------------------------------------------------
module esub_store (
   input  logic                           clock,
   input  logic                           reset,
   input  esub_pkg::wr_type               wr,
   input  logic [esub_pkg::IDX_BITS-1:0]  rd_idx,
   output logic [esub_pkg::OWNER_BITS-1:0] rd_owner,
   output logic [esub_pkg::EVENT_BITS-1:0] rd_code
);

   logic [esub_pkg::OWNER_BITS-1:0] owner_ff [esub_pkg::TABLE_DEPTH];
   logic [esub_pkg::EVENT_BITS-1:0] code_ff  [esub_pkg::TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < esub_pkg::TABLE_DEPTH; i++) begin
            owner_ff[i] <= '0;
         end
      end else if (wr.en) begin
         owner_ff[wr.idx] <= wr.owner;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.code_en) begin
         code_ff[wr.idx] <= wr.code;
      end
   end

   assign rd_owner = owner_ff[rd_idx];
   assign rd_code  = code_ff[rd_idx];

endmodule

// ===== rtl/core/esub_seq.sv =====
// ---------------------------------------------------------------------------
// Event subscription table: scan sequencer
// Walks the slots one per cycle through a shared compare unit while
// the output register is free and builds the result transactions in it.
// ---------------------------------------------------------------------------
module esub_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [7:0]                      catch_all_code,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  esub_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output esub_pkg::rsp_type               rsp_data,
   output esub_pkg::wr_type                wr,
   output logic [esub_pkg::IDX_BITS-1:0]   rd_idx,
   input  logic [esub_pkg::OWNER_BITS-1:0] rd_owner,
   input  logic [esub_pkg::EVENT_BITS-1:0] rd_code
);

   localparam logic [esub_pkg::IDX_BITS-1:0] LAST_IDX =
      esub_pkg::IDX_BITS'(esub_pkg::TABLE_DEPTH - 1);

   esub_pkg::state_type                state_ff, state_in;
   esub_pkg::req_type                  op_ff, op_in;
   logic                               drop_ff, drop_in;
   logic                               slot_ok_ff, slot_ok_in;
   logic                               flush_ff, flush_in;
   logic [esub_pkg::IDX_BITS-1:0]      ptr_ff, ptr_in;
   logic [esub_pkg::CNT_BITS-1:0]      count_ff, count_in;
   logic                               pend_ff, pend_in;
   logic [esub_pkg::IDX_BITS-1:0]      pend_slot_ff, pend_slot_in;
   logic [esub_pkg::OWNER_BITS-1:0]    pend_owner_ff, pend_owner_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   esub_pkg::rsp_type                  rsp_ff, rsp_in;

   logic                               accept;
   logic                               out_free;
   logic                               emit;
   logic                               done;
   esub_pkg::rsp_type                  res;
   logic                               occupied;
   logic                               owner_eq;
   logic                               code_eq;
   logic                               last_slot;
   logic [esub_pkg::CNT_BITS-1:0]      count_sat;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rd_idx    = ptr_ff;
   assign last_slot = (ptr_ff == LAST_IDX);

   // shared compare unit
   assign occupied  = (rd_owner != '0);
   assign owner_eq  = (rd_owner == op_ff.owner_id[esub_pkg::OWNER_BITS-1:0]);
   assign code_eq   = (rd_code == op_ff.event_code[esub_pkg::EVENT_BITS-1:0]);
   assign count_sat = (count_ff != '1) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         esub_pkg::S_IDLE: begin
            if (accept) begin
               state_in = esub_pkg::S_SCAN;
            end
         end
         esub_pkg::S_SCAN: begin
            if (done) begin
               state_in = esub_pkg::S_IDLE;
            end
         end
         default: state_in = esub_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == esub_pkg::S_IDLE);
      wr            = '0;
      emit          = 1'b0;
      done          = 1'b0;
      res           = '0;
      op_in         = op_ff;
      drop_in       = drop_ff;
      slot_ok_in    = slot_ok_ff;
      flush_in      = flush_ff;
      ptr_in        = ptr_ff;
      count_in      = count_ff;
      pend_in       = pend_ff;
      pend_slot_in  = pend_slot_ff;
      pend_owner_in = pend_owner_ff;

      if (accept) begin
         op_in      = req_data;
         drop_in    = (req_data.action == esub_pkg::ACT_DISPATCH) &&
                      (req_data.event_code <= catch_all_code);
         slot_ok_in = (32'(req_data.slot) < esub_pkg::TABLE_DEPTH);
         flush_in   = 1'b0;
         ptr_in     = (req_data.action == esub_pkg::ACT_UNSUB_SLOT) ?
                      esub_pkg::IDX_BITS'(req_data.slot) : '0;
         count_in   = '0;
         pend_in    = 1'b0;
      end

      if (state_ff == esub_pkg::S_SCAN && out_free) begin
         case (op_ff.action)
            esub_pkg::ACT_SUBSCRIBE: begin
               if (!occupied) begin
                  wr.en      = 1'b1;
                  wr.code_en = 1'b1;
                  wr.idx     = ptr_ff;
                  wr.owner   = op_ff.owner_id[esub_pkg::OWNER_BITS-1:0];
                  wr.code    = op_ff.event_code[esub_pkg::EVENT_BITS-1:0];
                  emit           = 1'b1;
                  done           = 1'b1;
                  res.status     = esub_pkg::ST_DONE;
                  res.slot_index = 4'(ptr_ff);
                  res.last       = 1'b1;
               end else if (last_slot) begin
                  emit       = 1'b1;
                  done       = 1'b1;
                  res.status = esub_pkg::ST_FULL;
                  res.last   = 1'b1;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
            esub_pkg::ACT_UNSUB_SLOT: begin
               emit     = 1'b1;
               done     = 1'b1;
               res.last = 1'b1;
               if (slot_ok_ff && occupied && owner_eq) begin
                  wr.en             = 1'b1;
                  wr.idx            = ptr_ff;
                  res.status        = esub_pkg::ST_DONE;
                  res.removed_count = 5'd1;
               end else begin
                  res.status = esub_pkg::ST_NO_MATCH;
               end
            end
            esub_pkg::ACT_UNSUB_MATCH: begin
               if (occupied && owner_eq && code_eq) begin
                  wr.en    = 1'b1;
                  wr.idx   = ptr_ff;
                  count_in = count_sat;
               end
               if (last_slot) begin
                  emit              = 1'b1;
                  done              = 1'b1;
                  res.last          = 1'b1;
                  res.removed_count = 5'(count_in);
                  res.status        = (count_in != '0) ? esub_pkg::ST_DONE :
                                      esub_pkg::ST_NO_MATCH;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
            default: begin
               if (drop_ff) begin
                  emit       = 1'b1;
                  done       = 1'b1;
                  res.status = esub_pkg::ST_DROPPED;
                  res.last   = 1'b1;
               end else if (flush_ff) begin
                  emit     = 1'b1;
                  done     = 1'b1;
                  res.last = 1'b1;
                  if (pend_ff) begin
                     res.status     = esub_pkg::ST_DONE;
                     res.slot_index = 4'(pend_slot_ff);
                     res.owner_out  = 8'(pend_owner_ff);
                  end else begin
                     res.status = esub_pkg::ST_NO_MATCH;
                  end
               end else begin
                  if (occupied && code_eq) begin
                     if (pend_ff) begin
                        emit           = 1'b1;
                        res.status     = esub_pkg::ST_DONE;
                        res.slot_index = 4'(pend_slot_ff);
                        res.owner_out  = 8'(pend_owner_ff);
                     end
                     pend_in       = 1'b1;
                     pend_slot_in  = ptr_ff;
                     pend_owner_in = rd_owner;
                  end
                  if (last_slot) begin
                     flush_in = 1'b1;
                  end else begin
                     ptr_in = ptr_ff + 1'b1;
                  end
               end
            end
         endcase
      end

      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_in       = emit ? res : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= esub_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         flush_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         flush_ff     <= flush_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      drop_ff       <= drop_in;
      slot_ok_ff    <= slot_ok_in;
      ptr_ff        <= ptr_in;
      count_ff      <= count_in;
      pend_slot_ff  <= pend_slot_in;
      pend_owner_ff <= pend_owner_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/event_subscription_table_top.sv =====
// ---------------------------------------------------------------------------
// Event subscription table: top level
// Request channel (req_), result channel (rsp_) and a catch-all code
// register written over the csr_ channel.
//
// Usage: each request transaction carries an action, owner id, event code
// and slot. Subscribe, unsubscribe by slot and unsubscribe by owner and
// event each give one result transaction; dispatch gives one per matching
// slot, in slot order, flagged last on the final one, or a single
// no-match or dropped result.
// Timing: a request is scanned one slot per cycle through one compare
// unit while the output register is free. Unsubscribe by slot checks its
// slot only, a dropped dispatch none; subscribe stops at the first free
// slot; unsubscribe by owner and event and dispatch visit every slot, and
// dispatch then flushes its held match. The first result shows in the
// cycle after its scan step; req_ready is low from acceptance until the
// final result is loaded. A stalled receiver holds the output register
// and freezes the scan. Reset empties every slot, clears the catch-all
// code and drops any result in flight.
// ---------------------------------------------------------------------------
module event_subscription_table_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  esub_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output esub_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);

   logic [7:0]                      catch_all_ff;
   esub_pkg::wr_type                wr;
   logic [esub_pkg::IDX_BITS-1:0]   rd_idx;
   logic [esub_pkg::OWNER_BITS-1:0] rd_owner;
   logic [esub_pkg::EVENT_BITS-1:0] rd_code;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         catch_all_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         catch_all_ff <= csr_data;
      end
   end

   esub_store u_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd_idx   (rd_idx),
      .rd_owner (rd_owner),
      .rd_code  (rd_code)
   );

   esub_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .catch_all_code (catch_all_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .wr             (wr),
      .rd_idx         (rd_idx),
      .rd_owner       (rd_owner),
      .rd_code        (rd_code)
   );

endmodule

// ===== rtl/core/esub_checker.sv =====
// ---------------------------------------------------------------------------
// Event subscription table: port checker
// Temporal checks on the top-level ports, bound to the top level.
// ---------------------------------------------------------------------------
`include "event_subscription_table_top_macros.svh"

module esub_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input esub_pkg::rsp_type rsp_data
);

   `ESUB_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid, "result valid after reset")

   `ESUB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   `ESUB_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready during scan")

   `ESUB_ASSERT_NOW(a_more_pending, rsp_valid && !rsp_data.last, !req_ready, "ready before last result")

endmodule

bind event_subscription_table_top esub_checker u_esub_checker (.*);
